/* src/kpsde_pkg.sv */
// shared types, key codes and the key-to-digit table for the keypad scanner
package kpsde_pkg;

    localparam int MATRIX_W   = 12;
    localparam int MAX_KEYS   = 12;
    localparam int KEY_W      = 4;
    localparam int ENTRY_W    = 16;
    localparam int TICK_W     = 32;
    localparam int INTERVAL_W = 16;

    localparam logic [KEY_W-1:0] NO_KEY   = 4'd12;
    localparam logic [KEY_W-1:0] STAR_KEY = 4'd9;
    localparam logic [KEY_W-1:0] ZERO_KEY = 4'd10;
    localparam logic [KEY_W-1:0] HASH_KEY = 4'd11;

    localparam logic [INTERVAL_W-1:0] SCAN_INTERVAL_RESET = 16'd100;

    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        logic                  is_digit;
        logic [3:0]            value;
    } digit_t;

    // one result beat
    typedef struct packed {
        logic                  scan_done;
        key_t                  key_index;
        logic                  new_press;
        logic [ENTRY_W-1:0]    entered_value;
        logic                  lamp_off;
        logic                  timer_start;
        logic [TICK_W-1:0]     start_time;
    } result_t;

    // digit value of a key position: keys 0-8 are 1-9, zero key is 0
    function automatic digit_t digit_of_key(input key_t key);
        digit_t d;
        d.is_digit = 1'b0;
        d.value    = 4'd0;
        if (key < STAR_KEY) begin
            d.is_digit = 1'b1;
            d.value    = key + 4'd1;
        end else if (key == ZERO_KEY) begin
            d.is_digit = 1'b1;
            d.value    = 4'd0;
        end
        return d;
    endfunction

endpackage

/* src/kpsde_key_pick.sv */
// priority encoder: lowest pressed key within the active part of the matrix
module kpsde_key_pick #(
    parameter int KEY_COUNT = 12
) (
    input  logic [kpsde_pkg::MATRIX_W-1:0] key_matrix,
    output kpsde_pkg::key_t                key_index
);
    import kpsde_pkg::*;

    // bits at or above the key count are ignored
    localparam int USED = (KEY_COUNT > MAX_KEYS) ? MAX_KEYS : KEY_COUNT;

    // scan downwards so the lowest set bit wins
    always_comb begin
        key_index = NO_KEY;
        for (int i = USED - 1; i >= 0; i--) begin
            if (key_matrix[i]) begin
                key_index = KEY_W'(i);
            end
        end
    end

endmodule

/* src/kpsde_scan_ctrl.sv */
// tick counting, scan timing, new-press detection and digit entry state
module kpsde_scan_ctrl #(
    parameter int KEY_COUNT = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step,
    input  logic [kpsde_pkg::MATRIX_W-1:0]   key_matrix,
    input  logic [kpsde_pkg::INTERVAL_W-1:0] scan_interval,
    output kpsde_pkg::result_t               result
);
    import kpsde_pkg::*;

    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [TICK_W-1:0]  last_scan_reg, last_scan_next;
    key_t               prev_key_reg, prev_key_next;
    logic [ENTRY_W-1:0] entry_reg, entry_next;
    logic [TICK_W-1:0]  start_reg, start_next;

    logic [TICK_W-1:0]  elapsed;
    logic               scan;
    key_t               picked;
    key_t               key;
    logic               fresh;
    digit_t             digit;
    logic [ENTRY_W-1:0] entry_times_ten;

    kpsde_key_pick #(
        .KEY_COUNT (KEY_COUNT)
    ) u_key_pick (
        .key_matrix (key_matrix),
        .key_index  (picked)
    );

    // interval test on the incremented tick, modulo 2^32
    always_comb begin
        tick_next = tick_reg + TICK_W'(1);
        elapsed   = tick_next - last_scan_reg;
        scan      = elapsed > {{(TICK_W-INTERVAL_W){1'b0}}, scan_interval};
        key       = scan ? picked : NO_KEY;
        fresh     = scan && (picked != NO_KEY) && (picked != prev_key_reg);
        digit     = digit_of_key(picked);
        entry_times_ten = (entry_reg << 3) + (entry_reg << 1);
    end

    // next state
    always_comb begin
        last_scan_next = last_scan_reg;
        prev_key_next  = prev_key_reg;
        entry_next     = entry_reg;
        start_next     = start_reg;
        if (scan) begin
            last_scan_next = tick_next;
            if (fresh) begin
                prev_key_next = picked;
                if (digit.is_digit) begin
                    entry_next = entry_times_ten + ENTRY_W'(digit.value);
                end else if (picked == HASH_KEY) begin
                    start_next = tick_next;
                end
            end else if (picked == NO_KEY) begin
                prev_key_next = NO_KEY;
            end
        end
    end

    // result of this tick
    always_comb begin
        result.scan_done     = scan;
        result.key_index     = key;
        result.new_press     = fresh;
        result.entered_value = entry_next;
        result.lamp_off      = fresh && digit.is_digit;
        result.timer_start   = fresh && (picked == HASH_KEY);
        result.start_time    = start_next;
    end

    // state registers, advanced once per accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= '0;
            last_scan_reg <= '0;
            prev_key_reg  <= NO_KEY;
            entry_reg     <= '0;
            start_reg     <= '0;
        end else if (step) begin
            tick_reg      <= tick_next;
            last_scan_reg <= last_scan_next;
            prev_key_reg  <= prev_key_next;
            entry_reg     <= entry_next;
            start_reg     <= start_next;
        end
    end

endmodule

/* src/keypad_scan_digit_entry.sv */
// top level of the keypad scanner with decimal digit entry
// Each input beat is one tick carrying a sampled key matrix; every beat gives
// exactly one result beat in the following cycle. One beat is taken per cycle
// unless stalled: the tick state is updated in a single combinational pass
// (32-bit increment and interval compare, priority encode, times-ten add) and
// the result lands in an output register. s_ready is high whenever that
// register is empty or is being emptied in the same cycle, so a stall on the
// result side holds the input side only while a finished result is waiting.
module keypad_scan_digit_entry #(
    parameter int KEY_ROWS = 4,
    parameter int KEY_COLS = 3
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [kpsde_pkg::INTERVAL_W-1:0]  cfg_wr_data,
    // input ticks
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [kpsde_pkg::MATRIX_W-1:0]    s_key_matrix,
    // results
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_scan_done,
    output logic [kpsde_pkg::KEY_W-1:0]       m_key_index,
    output logic                              m_new_press,
    output logic [kpsde_pkg::ENTRY_W-1:0]     m_entered_value,
    output logic                              m_lamp_off,
    output logic                              m_timer_start,
    output logic [kpsde_pkg::TICK_W-1:0]      m_start_time
);
    import kpsde_pkg::*;

    localparam int KEY_COUNT = KEY_ROWS * KEY_COLS;

    logic [INTERVAL_W-1:0] interval_reg;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg;
    result_t               result;
    logic                  step;

    assign s_ready = !out_valid_reg || m_ready;
    assign step    = s_valid && s_ready;

    // scan interval register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= SCAN_INTERVAL_RESET;
        end else if (cfg_wr_en) begin
            interval_reg <= cfg_wr_data;
        end
    end

    kpsde_scan_ctrl #(
        .KEY_COUNT (KEY_COUNT)
    ) u_scan_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .key_matrix    (s_key_matrix),
        .scan_interval (interval_reg),
        .result        (result)
    );

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_scan_done     = out_reg.scan_done;
    assign m_key_index     = out_reg.key_index;
    assign m_new_press     = out_reg.new_press;
    assign m_entered_value = out_reg.entered_value;
    assign m_lamp_off      = out_reg.lamp_off;
    assign m_timer_start   = out_reg.timer_start;
    assign m_start_time    = out_reg.start_time;

endmodule

/* dv/tb_keypad_scan_digit_entry.sv */
// testbench for the keypad scanner: a tick-by-tick predictor checks every result beat
module tb_keypad_scan_digit_entry;
    timeunit 1ns;
    timeprecision 1ps;

    import kpsde_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_TICKS = 75;
    localparam int WIDE_TICKS   = 40;
    localparam int DRAIN_CYCLES = 4;

    logic                    aclk         = 1'b0;
    logic                    aresetn      = 1'b0;
    logic                    cfg_wr_en    = 1'b0;
    logic [INTERVAL_W-1:0]   cfg_wr_data  = '0;
    logic                    s_valid      = 1'b0;
    logic                    s_ready;
    logic [MATRIX_W-1:0]     s_key_matrix = '0;
    logic                    m_valid;
    logic                    m_ready      = 1'b0;
    logic                    m_scan_done;
    logic [KEY_W-1:0]        m_key_index;
    logic                    m_new_press;
    logic [ENTRY_W-1:0]      m_entered_value;
    logic                    m_lamp_off;
    logic                    m_timer_start;
    logic [TICK_W-1:0]       m_start_time;

    // predictor state
    logic [INTERVAL_W-1:0]   scan_every;
    logic [TICK_W-1:0]       tick_count;
    logic [TICK_W-1:0]       last_scan_at;
    key_t                    held_key;
    logic [ENTRY_W-1:0]      entry_value;
    logic [TICK_W-1:0]       timer_mark;

    result_t                 outcome_q[$];
    int                      error_count  = 0;
    int                      cycle_count  = 0;
    int                      src_idle_pct = 0;
    int                      snk_stall_pct = 0;

    keypad_scan_digit_entry u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_key_matrix    (s_key_matrix),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scan_done     (m_scan_done),
        .m_key_index     (m_key_index),
        .m_new_press     (m_new_press),
        .m_entered_value (m_entered_value),
        .m_lamp_off      (m_lamp_off),
        .m_timer_start   (m_timer_start),
        .m_start_time    (m_start_time)
    );

    // clock
    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    function automatic void clear_predictor();
        scan_every   = SCAN_INTERVAL_RESET;
        tick_count   = '0;
        last_scan_at = '0;
        held_key     = NO_KEY;
        entry_value  = '0;
        timer_mark   = '0;
    endfunction

    // one tick: advance the count, maybe scan, and give the result beat
    function automatic result_t tick_outcome(input logic [MATRIX_W-1:0] matrix);
        result_t          r;
        key_t             key;
        logic [TICK_W-1:0] elapsed;
        logic [31:0]      grown;
        logic [3:0]       digit;
        logic             is_digit;
        r        = '0;
        key      = NO_KEY;
        digit    = 4'd0;
        is_digit = 1'b0;
        tick_count = tick_count + 1'b1;
        elapsed    = tick_count - last_scan_at;
        if (elapsed > TICK_W'(scan_every)) begin
            r.scan_done  = 1'b1;
            last_scan_at = tick_count;
            // lowest pressed key wins
            for (int i = MAX_KEYS - 1; i >= 0; i--) begin
                if (matrix[i]) key = key_t'(i);
            end
            if (key != NO_KEY && key != held_key) begin
                r.new_press = 1'b1;
                if (key < STAR_KEY) begin
                    is_digit = 1'b1;
                    digit    = key + 4'd1;
                end else if (key == ZERO_KEY) begin
                    is_digit = 1'b1;
                end
                if (is_digit) begin
                    r.lamp_off  = 1'b1;
                    grown       = entry_value * 32'd10 + digit;
                    entry_value = grown[ENTRY_W-1:0];
                end else if (key == HASH_KEY) begin
                    r.timer_start = 1'b1;
                    timer_mark    = tick_count;
                end
                held_key = key;
            end else if (key == NO_KEY) begin
                held_key = NO_KEY;
            end
        end
        r.key_index     = key;
        r.entered_value = entry_value;
        r.start_time    = timer_mark;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // result checker
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (outcome_q.size() == 0) begin
                $error("result beat with no tick outstanding");
                error_count++;
            end else begin
                want = outcome_q.pop_front();
                check_field("scan_done",     want.scan_done,     m_scan_done);
                check_field("key_index",     want.key_index,     m_key_index);
                check_field("new_press",     want.new_press,     m_new_press);
                check_field("entered_value", want.entered_value, m_entered_value);
                check_field("lamp_off",      want.lamp_off,      m_lamp_off);
                check_field("timer_start",   want.timer_start,   m_timer_start);
                check_field("start_time",    want.start_time,    m_start_time);
            end
        end
    end

    // send one tick beat, with a random gap in front of it
    task automatic send_tick(input logic [MATRIX_W-1:0] matrix);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_key_matrix <= matrix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        outcome_q.push_back(tick_outcome(matrix));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
    endtask

    // register write with the block idle
    task automatic set_scan_interval(input logic [INTERVAL_W-1:0] value);
        wait_drained();
        repeat (2) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        scan_every  = value;
    endtask

    // mostly single keys, holds and releases, some arbitrary chords
    function automatic logic [MATRIX_W-1:0] random_matrix(input logic [MATRIX_W-1:0] held);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) return '0;
        if (pick < 65) return MATRIX_W'(1) << $urandom_range(0, MAX_KEYS - 1);
        if (pick < 85) return held;
        return MATRIX_W'($urandom);
    endfunction

    task automatic run_ticks(input int count);
        logic [MATRIX_W-1:0] matrix;
        matrix = '0;
        repeat (count) begin
            matrix = random_matrix(matrix);
            send_tick(matrix);
        end
    endtask

    // reset interval: scans only every hundred and first tick
    task automatic test_reset_defaults();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        run_ticks(250);
    endtask

    // every key, chords, holds, releases and entry wrap with a scan on each tick
    task automatic test_directed_keys();
        set_scan_interval('0);
        send_tick('0);
        for (int i = 0; i < MAX_KEYS; i++) send_tick(MATRIX_W'(1) << i);
        send_tick(12'h800);
        send_tick('0);
        send_tick(12'h800);
        send_tick(12'hFFF);
        send_tick(12'hFFF);
        send_tick(12'h600);
        send_tick(12'h100);
        send_tick(12'h080);
        send_tick(12'h100);
        send_tick(12'h080);
        send_tick('0);
    endtask

    task automatic test_sender_idle();
        set_scan_interval(16'd1);
        src_idle_pct  = 82;
        snk_stall_pct = 0;
        run_ticks(RANDOM_TICKS);
    endtask

    task automatic test_receiver_stall();
        set_scan_interval(16'd2);
        src_idle_pct  = 0;
        snk_stall_pct = 82;
        run_ticks(RANDOM_TICKS);
    endtask

    task automatic test_both_idle();
        set_scan_interval('0);
        src_idle_pct  = 7;
        snk_stall_pct = 7;
        run_ticks(RANDOM_TICKS);
    endtask

    task automatic test_no_idle();
        set_scan_interval(16'd3);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        run_ticks(RANDOM_TICKS);
    endtask

    // widest interval: no scan at all within a short burst of ticks
    task automatic test_widest_interval();
        set_scan_interval('1);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        run_ticks(WIDE_TICKS);
    endtask

    // sequence
    initial begin
        clear_predictor();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_keys();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_no_idle();
        test_widest_interval();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sim.f */
src/kpsde_pkg.sv
src/kpsde_key_pick.sv
src/kpsde_scan_ctrl.sv
src/keypad_scan_digit_entry.sv
dv/tb_keypad_scan_digit_entry.sv
